// ----- sv/soss_pkg.sv -----
// Shared types and constants for the sphere overlap search unit.
package soss_pkg;

    localparam int COORD_W     = 32;
    localparam int RADIUS_W    = 31;
    localparam int IDX_W       = 10;
    localparam int TOL_W       = 31;
    localparam int EIU_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int GAP_W       = ROOT_W + 1;
    localparam int DEPTH_SCALE = 100000;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES   = 2'd1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic                placed;
        logic [RADIUS_W-1:0] radius;
        logic [COORD_W-1:0]  z;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  x;
    } entry_t;

    // travels alongside each scanned entry
    typedef struct packed {
        logic             vld;
        logic             last;
        logic [IDX_W-1:0] idx;
        logic [31:0]      rsum;
    } side_t;

endpackage

// ----- sv/soss_store.sv -----
// Sphere table memory: one write port, one registered read port.
module soss_store #(
    parameter int ENTRIES = 1024,
    parameter int AW      = 10
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  soss_pkg::entry_t      wdata,
    input  logic [AW-1:0]         raddr,
    output soss_pkg::entry_t      rdata
);

    soss_pkg::entry_t mem [0:ENTRIES-1];
    soss_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/soss_isqrt.sv -----
// Pipelined floor square root, one result bit per stage.
module soss_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [soss_pkg::SUM_W-1:0]    rad,
    input  soss_pkg::side_t               side_in,
    output logic [soss_pkg::ROOT_W-1:0]   root,
    output soss_pkg::side_t               side_out
);

    localparam int NST   = soss_pkg::ROOT_W;
    localparam int REM_W = soss_pkg::ROOT_W + 3;
    localparam int SW    = soss_pkg::SUM_W;
    localparam int RW    = soss_pkg::ROOT_W;

    logic [REM_W-1:0]      rem_reg  [1:NST];
    logic [RW-1:0]         res_reg  [1:NST];
    logic [SW-1:0]         rad_reg  [1:NST];
    soss_pkg::side_t       side_reg [1:NST];

    genvar k;
    generate
        for (k = 0; k < NST; k++)
        begin : g_stage
            logic [REM_W-1:0] rem_in;
            logic [RW-1:0]    res_in;
            logic [SW-1:0]    rad_in;
            soss_pkg::side_t  side_k;
            logic [REM_W+1:0] cand;
            logic [REM_W+1:0] trial;
            logic             ge;
            logic [REM_W+1:0] diff;

            if (k == 0)
            begin : g_first
                assign rem_in = '0;
                assign res_in = '0;
                assign rad_in = rad;
                assign side_k = side_in;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k];
                assign res_in = res_reg[k];
                assign rad_in = rad_reg[k];
                assign side_k = side_reg[k];
            end

            assign cand  = {rem_in, rad_in[SW-1 -: 2]};
            assign trial = {3'b000, res_in, 2'b01};
            assign ge    = (cand >= trial);
            assign diff  = ge ? (cand - trial) : cand;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg[k+1] <= '0;
                end
                else
                begin
                    side_reg[k+1] <= side_k;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k+1] <= diff[REM_W-1:0];
                res_reg[k+1] <= {res_in[RW-2:0], ge};
                rad_reg[k+1] <= {rad_in[SW-3:0], 2'b00};
            end
        end
    endgenerate

    assign root     = res_reg[NST];
    assign side_out = side_reg[NST];

endmodule

// ----- sv/soss_dist.sv -----
// Distance unit: differences, squares, sum, square root and surface gap.
module soss_dist (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [soss_pkg::COORD_W-1:0]  qx,
    input  logic signed [soss_pkg::COORD_W-1:0]  qy,
    input  logic signed [soss_pkg::COORD_W-1:0]  qz,
    input  logic [soss_pkg::RADIUS_W-1:0]        qr,
    input  soss_pkg::entry_t                     rdata,
    input  soss_pkg::side_t                      side_in,
    output logic signed [soss_pkg::GAP_W-1:0]    gap,
    output soss_pkg::side_t                      side_out
);

    localparam int CW = soss_pkg::COORD_W;

    logic [CW:0]            dx, dy, dz;
    logic [CW-1:0]          ax_reg, ay_reg, az_reg;
    logic [2*CW-1:0]        sx_reg, sy_reg, sz_reg;
    logic [soss_pkg::SUM_W-1:0] sum_reg;
    soss_pkg::side_t        side_a, side_a_reg, side_b_reg, side_c_reg, side_q, side_d_reg;
    logic [soss_pkg::ROOT_W-1:0] root;
    logic signed [soss_pkg::GAP_W-1:0] gap_reg;

    assign dx = {qx[CW-1], qx} - {rdata.x[CW-1], rdata.x};
    assign dy = {qy[CW-1], qy} - {rdata.y[CW-1], rdata.y};
    assign dz = {qz[CW-1], qz} - {rdata.z[CW-1], rdata.z};

    always_comb
    begin
        side_a      = side_in;
        side_a.vld  = side_in.vld & rdata.placed;
        side_a.rsum = {1'b0, qr} + {1'b0, rdata.radius};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_a_reg <= '0;
            side_b_reg <= '0;
            side_c_reg <= '0;
            side_d_reg <= '0;
        end
        else
        begin
            side_a_reg <= side_a;
            side_b_reg <= side_a_reg;
            side_c_reg <= side_b_reg;
            side_d_reg <= side_q;
        end
    end

    always_ff @(posedge clk)
    begin
        // |difference| is below 2^32, so it fits the coordinate width
        ax_reg  <= dx[CW] ? CW'(-dx) : dx[CW-1:0];
        ay_reg  <= dy[CW] ? CW'(-dy) : dy[CW-1:0];
        az_reg  <= dz[CW] ? CW'(-dz) : dz[CW-1:0];
        sx_reg  <= ax_reg * ax_reg;
        sy_reg  <= ay_reg * ay_reg;
        sz_reg  <= az_reg * az_reg;
        sum_reg <= {2'b00, sx_reg} + {2'b00, sy_reg} + {2'b00, sz_reg};
        gap_reg <= $signed({1'b0, root}) - $signed({2'b00, side_q.rsum});
    end

    soss_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .rad      (sum_reg),
        .side_in  (side_c_reg),
        .root     (root),
        .side_out (side_q)
    );

    assign gap      = gap_reg;
    assign side_out = side_d_reg;

endmodule

// ----- sv/sphere_overlap_search_unit.sv -----
// Sphere overlap search unit. After reset the unit runs a clearing pass over
// the table with busy high. A write item's result strobes on done in the next
// cycle. A query streams entries 0 .. n-1, n = min(entries_in_use, ENTRIES),
// through the distance unit at one entry per cycle, and its depth is set mostly
// by the bit-per-stage square root; busy stays high until its result strobes
// on done. Results are shown for exactly one cycle and cannot be held off.
module sphere_overlap_search_unit #(
    parameter int ENTRIES   = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  func,
    input  logic [soss_pkg::IDX_W-1:0]            index,
    input  logic signed [soss_pkg::COORD_W-1:0]   pos_x,
    input  logic signed [soss_pkg::COORD_W-1:0]   pos_y,
    input  logic signed [soss_pkg::COORD_W-1:0]   pos_z,
    input  logic [soss_pkg::RADIUS_W-1:0]         radius,
    input  logic                                  placed,
    output logic                                  done,
    output logic                                  clear,
    output logic                                  deepest_valid,
    output logic [soss_pkg::IDX_W-1:0]            deepest_index,
    input  logic                                  cfg_we,
    input  logic [soss_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [soss_pkg::TOL_W-1:0]            cfg_data
);

    localparam int AW        = $clog2(ENTRIES);
    localparam int DEPTH_LIM = (1 << FRAC_BITS) / soss_pkg::DEPTH_SCALE;
    localparam int GW        = soss_pkg::GAP_W;

    soss_pkg::state_t state_reg, state_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic [AW:0]      n_reg, lastc_reg;
    logic [AW:0]      n_sat;
    logic [soss_pkg::TOL_W-1:0] tol_reg;
    logic [soss_pkg::EIU_W-1:0] eiu_reg;
    logic signed [soss_pkg::COORD_W-1:0] qx_reg, qy_reg, qz_reg;
    logic [soss_pkg::RADIUS_W-1:0]       qr_reg;
    logic [soss_pkg::IDX_W-1:0]          excl_reg;

    logic             accept, q_start, w_start;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    soss_pkg::entry_t mem_wdata, rdata;
    soss_pkg::side_t  side_issue, side_s1_reg, side_s;
    logic signed [GW-1:0] gap_s;

    logic             clr_acc_reg, clr_acc_next;
    logic             val_acc_reg, val_acc_next;
    logic signed [GW-1:0] best_reg, best_next;
    logic [soss_pkg::IDX_W-1:0] bidx_reg, bidx_next;
    logic             conflict, deep;

    logic             done_reg, clear_reg, dval_reg;
    logic [soss_pkg::IDX_W-1:0] didx_reg;

    assign accept  = start & ~busy;
    assign q_start = accept & (func == soss_pkg::FUNC_QUERY);
    assign w_start = accept & (func == soss_pkg::FUNC_WRITE);

    assign n_sat = (32'(eiu_reg) > ENTRIES) ? (AW+1)'(ENTRIES) : (AW+1)'(eiu_reg);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
            eiu_reg <= soss_pkg::EIU_W'(1024);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                soss_pkg::REG_TOLERANCE: tol_reg <= cfg_data;
                soss_pkg::REG_ENTRIES:   eiu_reg <= cfg_data[soss_pkg::EIU_W-1:0];
                default:                 ;
            endcase
        end
    end

    // state machine: next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            soss_pkg::ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(ENTRIES - 1))
                begin
                    state_next = soss_pkg::ST_IDLE;
                    cnt_next   = '0;
                end
            end
            soss_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (q_start)
                begin
                    state_next = soss_pkg::ST_ISSUE;
                end
            end
            soss_pkg::ST_ISSUE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lastc_reg)
                begin
                    state_next = soss_pkg::ST_DRAIN;
                end
            end
            soss_pkg::ST_DRAIN:
            begin
                if (side_s.last)
                begin
                    state_next = soss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = soss_pkg::ST_IDLE;
            end
        endcase
    end

    // state machine: outputs
    always_comb
    begin
        busy      = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[AW-1:0];
        mem_wdata = '0;
        side_issue = '0;
        case (state_reg)
            soss_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            soss_pkg::ST_IDLE:
            begin
                busy      = 1'b0;
                mem_we    = w_start & (32'(index) < ENTRIES);
                mem_waddr = AW'(index);
                mem_wdata = '{placed: placed, radius: radius,
                              z: pos_z, y: pos_y, x: pos_x};
            end
            soss_pkg::ST_ISSUE:
            begin
                side_issue.vld  = (cnt_reg < n_reg) & (32'(cnt_reg) != 32'(excl_reg));
                side_issue.last = (cnt_reg == lastc_reg);
                side_issue.idx  = soss_pkg::IDX_W'(cnt_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= soss_pkg::ST_CLEAR;
            cnt_reg     <= '0;
            side_s1_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            side_s1_reg <= side_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_start)
        begin
            qx_reg    <= pos_x;
            qy_reg    <= pos_y;
            qz_reg    <= pos_z;
            qr_reg    <= radius;
            excl_reg  <= index;
            n_reg     <= n_sat;
            lastc_reg <= (n_sat == '0) ? '0 : n_sat - 1'b1;
        end
    end

    soss_store #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rdata)
    );

    soss_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .qz       (qz_reg),
        .qr       (qr_reg),
        .rdata    (rdata),
        .side_in  (side_s1_reg),
        .gap      (gap_s),
        .side_out (side_s)
    );

    // deepest-gap selection; scan order is ascending so ties keep the lower index
    assign conflict = $signed({gap_s[GW-1], gap_s}) < -$signed({4'b0000, tol_reg});
    assign deep     = $signed({gap_s[GW-1], gap_s}) < -$signed((GW+1)'(DEPTH_LIM));

    always_comb
    begin
        clr_acc_next = clr_acc_reg;
        val_acc_next = val_acc_reg;
        best_next    = best_reg;
        bidx_next    = bidx_reg;
        if (q_start)
        begin
            clr_acc_next = 1'b1;
            val_acc_next = 1'b0;
            bidx_next    = '0;
        end
        else if (side_s.vld && conflict)
        begin
            clr_acc_next = 1'b0;
            if (deep && (!val_acc_reg || gap_s < best_reg))
            begin
                val_acc_next = 1'b1;
                best_next    = gap_s;
                bidx_next    = side_s.idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_acc_reg <= 1'b1;
            val_acc_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            clr_acc_reg <= clr_acc_next;
            val_acc_reg <= val_acc_next;
            done_reg    <= w_start | side_s.last;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        bidx_reg <= bidx_next;
        if (w_start)
        begin
            clear_reg <= 1'b1;
            dval_reg  <= 1'b0;
            didx_reg  <= '0;
        end
        else
        begin
            clear_reg <= clr_acc_next;
            dval_reg  <= val_acc_next;
            didx_reg  <= val_acc_next ? bidx_next : '0;
        end
    end

    assign done          = done_reg;
    assign clear         = clear_reg;
    assign deepest_valid = dval_reg;
    assign deepest_index = didx_reg;

`ifndef ASSERT_OFF
    a_deep_not_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done && deepest_valid |-> !clear)
        else $error("deepest entry reported on a clear result");

    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !deepest_valid |-> deepest_index == '0)
        else $error("deepest_index not zero without a deepest entry");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted item neither busy nor answered");

    a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        side_s.last |-> state_reg == soss_pkg::ST_DRAIN)
        else $error("scan tail left the pipeline outside drain");
`endif

endmodule
